[sv/u8vd_pkg.sv]
// Shared types and constants for the UTF-8 validating decoder.
// Used by the front end, the command queue, the back end and the top level.
package u8vd_pkg;

    // Lead byte ranges.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;

    // Continuation byte ranges, including the narrowed second-byte ranges.
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] E0_CONT_LO  = 8'hA0;
    localparam logic [7:0] ED_CONT_HI  = 8'h9F;
    localparam logic [7:0] F0_CONT_LO  = 8'h90;
    localparam logic [7:0] F4_CONT_HI  = 8'h8F;
    localparam logic [7:0] CONT_MASK   = 8'h3F;
    localparam logic [7:0] LINE_FEED   = 8'h0A;

    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 160;
    localparam int QUEUE_DEPTH = 4;

    // One classified byte: a run of results, all errors except possibly the
    // last one, which may be a valid character.
    typedef struct packed {
        logic [1:0]       n_m1;       // number of results minus one
        logic             last_valid; // last result is a valid character
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             nl;         // newline, counted with the last result
    } t_cmd;

endpackage

[sv/u8vd_front.sv]
// Front end of the UTF-8 decoder: accepts bytes, tracks the open sequence
// and turns each byte that gives results into a result command. Depends on u8vd_pkg.
module u8vd_front import u8vd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    output logic        o_ready,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [1:0]      r_pend, n_pend;
    logic [2:0]      r_len, n_len;
    logic [7:0]      r_lead, n_lead;
    logic [CP_W-1:0] r_accum, n_accum;

    logic            accept;
    logic            open_seq;
    logic            fits;
    logic [7:0]      lo, hi;
    logic [CP_W-1:0] acc_sh;
    logic [1:0]      pend_dec;
    logic [2:0]      held_now, held_after, pre, n_res;
    logic            is_ascii, is_l2, is_l3, is_l4;
    t_cmd            cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        open_seq   = (r_len != 3'd0);
        lo         = CONT_LO;
        hi         = CONT_HI;
        // The second byte of some leads has a narrower range.
        if (({1'b0, r_pend} + 3'd1) == r_len) begin
            if (r_lead == LEAD_E0) begin
                lo = E0_CONT_LO;
            end else if (r_lead == LEAD_ED) begin
                hi = ED_CONT_HI;
            end else if (r_lead == LEAD_F0) begin
                lo = F0_CONT_LO;
            end else if (r_lead == LEAD_F4) begin
                hi = F4_CONT_HI;
            end
        end
        fits       = (i_data >= lo) && (i_data <= hi);
        acc_sh     = {r_accum[CP_W-7:0], i_data[5:0]};
        pend_dec   = r_pend - 2'd1;
        held_now   = r_len - 3'd1 - {1'b0, r_pend};
        held_after = r_len - 3'd1 - {1'b0, pend_dec};
        is_ascii   = (i_data < ASCII_LIMIT);
        is_l2      = (i_data >= LEAD2_LO) && (i_data <= LEAD2_HI);
        is_l3      = (i_data >= LEAD3_LO) && (i_data <= LEAD3_HI);
        is_l4      = (i_data >= LEAD4_LO) && (i_data <= LEAD4_HI);

        n_pend  = 2'd0;
        n_len   = 3'd0;
        n_lead  = 8'd0;
        n_accum = '0;
        n_res   = 3'd0;
        pre     = 3'd0;
        cmd     = '0;

        if (open_seq && fits) begin
            if (pend_dec == 2'd0) begin
                n_res          = 3'd1;
                cmd.last_valid = 1'b1;
                cmd.cp         = acc_sh;
                cmd.len        = r_len;
            end else if (i_last) begin
                // Stream ends inside the sequence: lead plus held bytes.
                n_res = held_after + 3'd1;
            end else begin
                n_pend  = pend_dec;
                n_len   = r_len;
                n_lead  = r_lead;
                n_accum = acc_sh;
            end
        end else begin
            // A rejected sequence gives one error for the lead and one for
            // each held continuation byte, then the byte is scanned as a lead.
            if (open_seq) begin
                pre = held_now + 3'd1;
            end
            if (is_ascii) begin
                n_res          = pre + 3'd1;
                cmd.last_valid = 1'b1;
                cmd.cp         = CP_W'(i_data);
                cmd.len        = 3'd1;
                cmd.nl         = (i_data == LINE_FEED);
            end else if (is_l2 || is_l3 || is_l4) begin
                if (i_last) begin
                    n_res = pre + 3'd1;
                end else begin
                    n_res  = pre;
                    n_lead = i_data;
                    if (is_l2) begin
                        n_len   = 3'd2;
                        n_pend  = 2'd1;
                        n_accum = CP_W'(i_data[4:0]);
                    end else if (is_l3) begin
                        n_len   = 3'd3;
                        n_pend  = 2'd2;
                        n_accum = CP_W'(i_data[3:0]);
                    end else begin
                        n_len   = 3'd4;
                        n_pend  = 2'd3;
                        n_accum = CP_W'(i_data[2:0]);
                    end
                end
            end else begin
                n_res = pre + 3'd1;
            end
        end
        cmd.n_m1 = 2'(n_res - 3'd1);
    end

    assign o_push = accept && (n_res != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 2'd0;
            r_len   <= 3'd0;
            r_lead  <= 8'd0;
            r_accum <= '0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_len   <= n_len;
            r_lead  <= n_lead;
            r_accum <= n_accum;
        end
    end

endmodule

[sv/u8vd_queue.sv]
// Short command queue between the decoder front end and back end.
// Depends on u8vd_pkg for the command type and depth.
module u8vd_queue import u8vd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/u8vd_back.sv]
// Back end of the UTF-8 decoder: expands each command into result words,
// keeps the saturating totals and holds the output register. Uses u8vd_pkg.
module u8vd_back import u8vd_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_is_error,
    output logic [CP_W-1:0]        o_code_point,
    output logic [LEN_W-1:0]       o_char_length,
    output logic                   o_run_last,
    output logic [TOTAL_W-1:0]     o_line_total,
    output logic [TOTAL_W-1:0]     o_multibyte_total,
    output logic [TOTAL_W-1:0]     o_char_total,
    output logic [TOTAL_W-1:0]     o_error_total
);

    logic [1:0]             r_idx;
    logic                   r_ovalid;
    logic [COUNT_WIDTH-1:0] r_lines, r_multi, r_chars, r_errs;
    logic [COUNT_WIDTH-1:0] n_lines, n_multi, n_chars, n_errs;
    logic                   load, is_last, res_valid;

    assign load      = i_valid && (!r_ovalid || i_ready);
    assign is_last   = (r_idx == i_cmd.n_m1);
    assign res_valid = is_last && i_cmd.last_valid;
    assign o_pop     = load && is_last;
    assign o_valid   = r_ovalid;

    always_comb begin
        n_lines = r_lines;
        n_multi = r_multi;
        n_errs  = r_errs;
        n_chars = (r_chars == '1) ? r_chars : r_chars + 1'b1;
        if (is_last && i_cmd.nl && (r_lines != '1)) begin
            n_lines = r_lines + 1'b1;
        end
        if (!res_valid) begin
            if (r_errs != '1) begin
                n_errs = r_errs + 1'b1;
            end
        end else if ((i_cmd.len > 3'd1) && (r_multi != '1)) begin
            n_multi = r_multi + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
            r_lines  <= '0;
            r_multi  <= '0;
            r_chars  <= '0;
            r_errs   <= '0;
        end else if (load) begin
            r_idx    <= is_last ? 2'd0 : r_idx + 2'd1;
            r_ovalid <= 1'b1;
            r_lines  <= n_lines;
            r_multi  <= n_multi;
            r_chars  <= n_chars;
            r_errs   <= n_errs;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_is_error        <= !res_valid;
            o_code_point      <= res_valid ? i_cmd.cp : '0;
            o_char_length     <= res_valid ? i_cmd.len : '0;
            o_run_last        <= is_last;
            o_line_total      <= TOTAL_W'(n_lines);
            o_multibyte_total <= TOTAL_W'(n_multi);
            o_char_total      <= TOTAL_W'(n_chars);
            o_error_total     <= TOTAL_W'(n_errs);
        end
    end

endmodule

[sv/utf8_validating_decoder_core.sv]
// Strict UTF-8 validating decoder, top level.
// Byte stream in on the slave side, one result word per lead position out on
// the master side. Each accepted byte gives zero to four result words; tlast
// on the master side marks the last word caused by one input byte. Input
// tlast marks the end of the stream: an open sequence is flushed as errors.
// A word carries an error flag, the code point and its length (zero on
// error), and saturating totals of newlines, multibyte characters, lead
// positions and errors, counted up to and including that word.
// The first word of a byte reaches the master side through the command
// queue and then the output register. The front end takes one byte per cycle
// while the queue is not full; the back end sends one word per cycle while the
// receiver keeps tready high, so a byte that gives several words holds the
// back end until all of them are sent, and a four-entry command queue between
// them absorbs short error bursts before tready drops.
// Reset (i_rst_n low at a clock edge) closes any open sequence, empties the
// queue and output register and clears all totals.
// When the receiver holds tready low, the current word stays on the master
// side; the queue fills and then the slave side stops accepting bytes.
// Depends on u8vd_pkg, u8vd_front, u8vd_queue and u8vd_back.
module utf8_validating_decoder_core import u8vd_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] data_byte
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,   // stream_end
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] is_error, [21:1] code_point, [24:22] char_length,
    // [56:25] line_total, [88:57] multibyte_total, [120:89] char_total,
    // [152:121] error_total, [159:153] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast    // run_last
);

    localparam int PAD_W = OUT_TDATA_W - 1 - CP_W - LEN_W - 4 * TOTAL_W;

    logic               full, push, pop, q_valid;
    t_cmd               push_cmd, head_cmd;
    logic               is_error;
    logic [CP_W-1:0]    code_point;
    logic [LEN_W-1:0]   char_length;
    logic [TOTAL_W-1:0] line_total, multibyte_total, char_total, error_total;

    u8vd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    u8vd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    u8vd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_cmd             (head_cmd),
        .o_pop             (pop),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_is_error        (is_error),
        .o_code_point      (code_point),
        .o_char_length     (char_length),
        .o_run_last        (o_m_axis_tlast),
        .o_line_total      (line_total),
        .o_multibyte_total (multibyte_total),
        .o_char_total      (char_total),
        .o_error_total     (error_total)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, error_total, char_total, multibyte_total,
                             line_total, char_length, code_point, is_error};

endmodule

[bench/utf8_validating_decoder_core_tb.sv]
// Self-checking bench for utf8_validating_decoder_core: directed byte table, then
// random well-formed and broken UTF-8 under varying handshake idling and stalls.
// Depends on u8vd_pkg and the decoder RTL only.
module utf8_validating_decoder_core_tb import u8vd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PER_BYTE = 4;

    typedef struct {
        bit               err;
        bit [CP_W-1:0]    cp;
        bit [LEN_W-1:0]   len;
        bit               tlast;
        bit [TOTAL_W-1:0] lines;
        bit [TOTAL_W-1:0] multi;
        bit [TOTAL_W-1:0] chars;
        bit [TOTAL_W-1:0] errs;
    } t_result_word;

    typedef struct {
        bit [7:0]       din;
        bit             fin;
        int             n;    // number of words this byte gives
        bit             err;  // fields of the last of those words
        bit [CP_W-1:0]  cp;
        bit [LEN_W-1:0] len;
    } t_byte_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    utf8_validating_decoder_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Decoder state as seen by the predictor.
    bit [1:0]         need_cnt;
    bit [2:0]         seq_len;
    bit [7:0]         lead_b;
    bit [CP_W-1:0]    acc;
    bit [TOTAL_W-1:0] lines_cnt;
    bit [TOTAL_W-1:0] mb_cnt;
    bit [TOTAL_W-1:0] char_cnt;
    bit [TOTAL_W-1:0] err_cnt;

    t_result_word step_words[$];
    t_result_word pending_words[$];

    int  mismatch_cnt;
    int  bytes_sent;
    int  ends_sent;
    int  words_checked;
    int  error_words;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  stall_left;
    bit  hold_request;

    t_byte_row dir_rows[26] = '{
        '{8'h00, 1'b0, 1, 1'b0, 21'h000000, 3'd1},
        '{8'h7F, 1'b0, 1, 1'b0, 21'h00007F, 3'd1},
        '{8'h0A, 1'b0, 1, 1'b0, 21'h00000A, 3'd1},
        '{8'h80, 1'b0, 1, 1'b1, 21'h000000, 3'd0},
        '{8'hC1, 1'b0, 1, 1'b1, 21'h000000, 3'd0},
        '{8'hFF, 1'b0, 1, 1'b1, 21'h000000, 3'd0},
        '{8'hC2, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1, 1'b0, 21'h000080, 3'd2},
        '{8'hDF, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'hBF, 1'b0, 1, 1'b0, 21'h0007FF, 3'd2},
        '{8'hE0, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h9F, 1'b0, 2, 1'b1, 21'h000000, 3'd0},
        '{8'hED, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h9F, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'hBF, 1'b0, 1, 1'b0, 21'h00D7FF, 3'd3},
        '{8'hF4, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h8F, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'hBF, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'hBF, 1'b0, 1, 1'b0, 21'h10FFFF, 3'd4},
        '{8'hF0, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h90, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        // Broken four-byte run, then a new lead flushed by the stream end.
        '{8'hF0, 1'b1, 4, 1'b1, 21'h000000, 3'd0},
        '{8'hF4, 1'b0, 0, 1'b0, 21'h000000, 3'd0},
        '{8'h90, 1'b0, 2, 1'b1, 21'h000000, 3'd0},
        '{8'hE0, 1'b1, 1, 1'b1, 21'h000000, 3'd0}
    };

    function automatic bit [TOTAL_W-1:0] bump(bit [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void put_word(bit err, bit [CP_W-1:0] cp, bit [LEN_W-1:0] len);
        t_result_word w;
        if (step_words.size() >= MAX_PER_BYTE) begin
            return;
        end
        char_cnt = bump(char_cnt);
        if (err) begin
            err_cnt = bump(err_cnt);
        end else if (len > 1) begin
            mb_cnt = bump(mb_cnt);
        end
        w.err   = err;
        w.cp    = err ? '0 : cp;
        w.len   = err ? '0 : len;
        w.tlast = 1'b0;
        w.lines = lines_cnt;
        w.multi = mb_cnt;
        w.chars = char_cnt;
        w.errs  = err_cnt;
        step_words.push_back(w);
    endfunction

    function automatic void close_open();
        seq_len  = '0;
        need_cnt = '0;
        lead_b   = '0;
        acc      = '0;
    endfunction

    // The lead gives one error, and so does every continuation byte taken so far.
    function automatic void reject_open();
        int held;
        held = 0;
        if (int'(seq_len) > int'(need_cnt) + 1) begin
            held = int'(seq_len) - 1 - int'(need_cnt);
        end
        put_word(1'b1, '0, '0);
        for (int k = 0; k < held; k++) begin
            put_word(1'b1, '0, '0);
        end
        close_open();
    endfunction

    function automatic void scan_lead(bit [7:0] b);
        if (b == LINE_FEED) begin
            lines_cnt = bump(lines_cnt);
        end
        if (b < ASCII_LIMIT) begin
            put_word(1'b0, CP_W'(b), LEN_W'(1));
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            seq_len  = 3'd2;
            need_cnt = 2'd1;
            lead_b   = b;
            acc      = CP_W'(b[4:0]);
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            seq_len  = 3'd3;
            need_cnt = 2'd2;
            lead_b   = b;
            acc      = CP_W'(b[3:0]);
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            seq_len  = 3'd4;
            need_cnt = 2'd3;
            lead_b   = b;
            acc      = CP_W'(b[2:0]);
        end else begin
            put_word(1'b1, '0, '0);
        end
    endfunction

    // Range allowed for a continuation byte; the second byte of a few leads is narrower.
    function automatic void cont_bounds(bit [7:0] lead, bit second,
                                        output bit [7:0] lo, output bit [7:0] hi);
        lo = CONT_LO;
        hi = CONT_HI;
        if (second) begin
            if (lead == LEAD_E0) begin
                lo = E0_CONT_LO;
            end else if (lead == LEAD_ED) begin
                hi = ED_CONT_HI;
            end else if (lead == LEAD_F0) begin
                lo = F0_CONT_LO;
            end else if (lead == LEAD_F4) begin
                hi = F4_CONT_HI;
            end
        end
    endfunction

    function automatic void decode_byte(bit [7:0] b, bit fin);
        bit [7:0] lo;
        bit [7:0] hi;
        step_words.delete();
        if (seq_len != 0) begin
            cont_bounds(lead_b, int'(need_cnt) + 1 == int'(seq_len), lo, hi);
            if (b >= lo && b <= hi) begin
                acc = {acc[CP_W-7:0], b[5:0]};
                need_cnt = need_cnt - 1'b1;
                if (need_cnt == 0) begin
                    put_word(1'b0, acc, LEN_W'(seq_len));
                    close_open();
                end
            end else begin
                reject_open();
                scan_lead(b);
            end
        end else begin
            scan_lead(b);
        end
        if (fin && seq_len != 0) begin
            reject_open();
        end
        if (step_words.size() > 0) begin
            step_words[step_words.size()-1].tlast = 1'b1;
        end
        foreach (step_words[i]) begin
            pending_words.push_back(step_words[i]);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    function automatic void check_word();
        t_result_word w;
        logic [OUT_TDATA_W-1:0] d;
        d = o_m_axis_tdata;
        if (pending_words.size() == 0) begin
            $display("%0t: word with nothing expected, expected none, actual %h", $time, d);
            mismatch_cnt++;
            return;
        end
        w = pending_words.pop_front();
        words_checked++;
        if (w.err) begin
            error_words++;
        end
        check_field("is_error", w.err, d[0]);
        check_field("code_point", w.cp, d[21:1]);
        check_field("char_length", w.len, d[24:22]);
        check_field("line_total", w.lines, d[56:25]);
        check_field("multibyte_total", w.multi, d[88:57]);
        check_field("char_total", w.chars, d[120:89]);
        check_field("error_total", w.errs, d[152:121]);
        check_field("pad", '0, d[159:153]);
        check_field("run_last", w.tlast, o_m_axis_tlast);
    endfunction

    // Receiver: checks each accepted word, then drives tready for the next cycle.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                check_word();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(bit [7:0] b, bit fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= fin;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        decode_byte(b, fin);
        bytes_sent++;
        if (fin) begin
            ends_sent++;
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0);
    endtask

    // Continuation byte in [lo, hi], leaning on the edges of the range.
    function automatic bit [7:0] pick_cont(bit [7:0] lo, bit [7:0] hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic bit [7:0] pick_lead(bit [7:0] lo, bit [7:0] hi, bit [7:0] narrow_a,
                                           bit [7:0] narrow_b);
        case ($urandom_range(0, 3))
            0: return narrow_a;
            1: return narrow_b;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    // One character: mostly well formed, some cut short and then followed by a bad
    // byte, some plain noise.
    task automatic send_char();
        bit [7:0] seq[$];
        bit [7:0] lead;
        bit [7:0] lo;
        bit [7:0] hi;
        int       kind;
        int       full;
        int       keep;
        kind = $urandom_range(0, 99);
        if (kind < 28) begin
            seq.push_back(($urandom_range(0, 7) == 0) ? LINE_FEED : 8'($urandom_range(0, 127)));
        end else if (kind < 90) begin
            if (kind < 46) begin
                lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
            end else if (kind < 62 || kind >= 78) begin
                lead = pick_lead(LEAD3_LO, LEAD3_HI, LEAD_E0, LEAD_ED);
            end else begin
                lead = pick_lead(LEAD4_LO, LEAD4_HI, LEAD_F0, LEAD_F4);
            end
            if (kind >= 78 && $urandom_range(0, 1) == 0) begin
                lead = pick_lead(LEAD2_LO, LEAD4_HI, LEAD_F0, LEAD_F4);
            end
            full = (lead >= LEAD4_LO) ? 4 : (lead >= LEAD3_LO) ? 3 : 2;
            keep = (kind >= 78) ? $urandom_range(0, full - 2) : full - 1;
            seq.push_back(lead);
            for (int k = 0; k < keep; k++) begin
                cont_bounds(lead, k == 0, lo, hi);
                seq.push_back(pick_cont(lo, hi));
            end
            if (kind >= 78) begin
                // Offending byte: just outside the allowed range, or anything.
                cont_bounds(lead, keep == 0, lo, hi);
                case ($urandom_range(0, 2))
                    0: seq.push_back(lo - 8'd1);
                    1: seq.push_back(hi + 8'd1);
                    default: seq.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            seq.push_back(8'($urandom_range(0, 255)));
        end
        foreach (seq[i]) begin
            send_byte(seq[i], $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        #400_000;
        $display("Timeout at %0t with %0d words outstanding", $time, pending_words.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        send_idle_pct   = 20;
        recv_idle_pct   = 51;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].din, dir_rows[r].fin);
            if (step_words.size() != dir_rows[r].n) begin
                $display("%0t: row %0d word count mismatch, expected %0d, actual %0d",
                         $time, r, dir_rows[r].n, step_words.size());
                mismatch_cnt++;
            end else if (dir_rows[r].n > 0) begin
                check_field("table is_error", dir_rows[r].err, step_words[$].err);
                check_field("table code_point", dir_rows[r].cp, step_words[$].cp);
                check_field("table char_length", dir_rows[r].len, step_words[$].len);
            end
        end
        wait_drained();

        while (bytes_sent < 95) begin
            send_char();
        end
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 20;
        while (bytes_sent < 165) begin
            send_char();
        end
        wait_drained();

        // Receiver holds off while the sender keeps offering, so the queue fills
        // and the input side stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        while (bytes_sent < 195) begin
            send_char();
        end
        wait_drained();

        while (bytes_sent < 235) begin
            send_char();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d from the table, %0d stream ends) under three idle mixes",
                 bytes_sent, $size(dir_rows), ends_sent);
        $display("and one long receiver stall; checked %0d words, %0d of them errors.",
                 words_checked, error_words);
        if (mismatch_cnt == 0 && pending_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
